// ===== rtl/core/dahp_pkg.sv =====
`timescale 1ns / 1ps

package dahp_pkg;

	// One input beat: a header byte and its end marker
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last_byte;
	} req_t;

	// One result beat
	typedef struct packed {
		logic       value_valid;
		logic [7:0] value_byte;
		logic       lead_backslash;
		logic [3:0] field_code;
		logic       value_end;
		logic       header_done;
		logic       header_accepted;
		logic [2:0] reject_reason;
	} rsp_t;

	typedef enum logic [9:0] {
		PH_START       = 10'b00_0000_0001,
		PH_SCHEME      = 10'b00_0000_0010,
		PH_SCHEME_END  = 10'b00_0000_0100,
		PH_NAME        = 10'b00_0000_1000,
		PH_VALUE_START = 10'b00_0001_0000,
		PH_TOKEN       = 10'b00_0010_0000,
		PH_QUOTED      = 10'b00_0100_0000,
		PH_LWS         = 10'b00_1000_0000,
		PH_ERR_SYNTAX  = 10'b01_0000_0000,
		PH_ERR_SCHEME  = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [2:0] {
		REJ_NONE      = 3'd0,
		REJ_SYNTAX    = 3'd1,
		REJ_SCHEME    = 3'd2,
		REJ_MISSING   = 3'd3,
		REJ_NONCE_LEN = 3'd4,
		REJ_TRUNCATED = 3'd5
	} reject_t;

	localparam int unsigned NAME_COUNT = 9;
	localparam logic [3:0]  FIELD_UNKNOWN = 4'd0;
	localparam logic [3:0]  FIELD_NONCE   = 4'd4;
	localparam logic [7:0]  FIELDS_ALL    = 8'hff;
	localparam logic [6:0]  COUNT_MAX     = 7'd127;

	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DEL    = 8'h7f;

	// Token characters, one bit per 7-bit code; codes below 0x20 are never tokens
	localparam logic [127:0] TOKEN_MAP = {32'h57ffffff, 32'hc7fffffe, 32'h03ff6cf8, 32'h0};

	localparam logic [2:0] SCHEME_LEN = 3'd6;
	localparam logic [7:0] SCHEME_WORD [0:5] = '{"D", "i", "g", "e", "s", "t"};

	localparam logic [7:0] NAME_TABLE [0:8][0:7] = '{
		'{"u", "s", "e", "r", "n", "a", "m", "e"},
		'{"q", "o", "p", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"r", "e", "a", "l", "m", 8'h0, 8'h0, 8'h0},
		'{"n", "o", "n", "c", "e", 8'h0, 8'h0, 8'h0},
		'{"n", "c", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"u", "r", "i", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"c", "n", "o", "n", "c", "e", 8'h0, 8'h0},
		'{"r", "e", "s", "p", "o", "n", "s", "e"},
		'{"o", "p", "a", "q", "u", "e", 8'h0, 8'h0}
	};
	localparam logic [3:0] NAME_LEN [0:8] = '{4'd8, 4'd3, 4'd5, 4'd5, 4'd2, 4'd3, 4'd6,
		4'd8, 4'd6};

	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && TOKEN_MAP[c[6:0]];
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_CR) || (c == CH_LF) || (c == CH_SP) || (c == CH_HT);
	endfunction

endpackage

// ===== rtl/core/dahp_name_match.sv =====
`timescale 1ns / 1ps

// Narrow the set of known parameter names by one name byte, and decode the
// field code of the surviving name when the equals sign arrives.
module dahp_name_match import dahp_pkg::*; (
	input  logic                  restart,
	input  logic [NAME_COUNT-1:0] cands,
	input  logic [3:0]            pos,
	input  logic [7:0]            c,
	output logic [NAME_COUNT-1:0] cands_next,
	output logic [3:0]            pos_next,
	output logic [3:0]            field
);

	logic [NAME_COUNT-1:0] cands_eff;
	logic [3:0]            pos_eff;

	assign cands_eff = restart ? '1 : cands;
	assign pos_eff   = restart ? 4'd0 : pos;
	assign pos_next  = (pos_eff == 4'd15) ? pos_eff : pos_eff + 4'd1;

	always_comb begin
		for (int i = 0; i < NAME_COUNT; i++) begin
			cands_next[i] = cands_eff[i] && (pos_eff < NAME_LEN[i]) &&
				(c == NAME_TABLE[i][pos_eff[2:0]]);
		end
	end

	// Later entries win, as in the scan order of the table
	always_comb begin
		field = FIELD_UNKNOWN;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (cands[i] && (NAME_LEN[i] == pos))
				field = 4'(i + 1);
		end
	end

endmodule

// ===== rtl/core/dahp_parse.sv =====
`timescale 1ns / 1ps

// Parser state and the transition for one header byte.
module dahp_parse import dahp_pkg::*; #(
	parameter int unsigned NONCE_CHARS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t item,
	output rsp_t res
);

	phase_t                phase_q, phase_n;
	logic [2:0]            spos_q, spos_n;
	logic                  smatch_q, smatch_n;
	logic [NAME_COUNT-1:0] cands_q, cands_n;
	logic [3:0]            npos_q, npos_n;
	logic [3:0]            field_q, field_n;
	logic                  comma_q, comma_n;
	logic                  esc_q, esc_n;
	logic                  nonempty_q, nonempty_n;
	logic [6:0]            count_q, count_n;
	logic [7:0]            fields_q, fields_n;
	logic                  nonce_ok_q, nonce_ok_n;

	logic [NAME_COUNT-1:0] nm_cands;
	logic [3:0]            nm_pos;
	logic [3:0]            nm_field;

	logic [7:0] c;
	logic       tok, sp;
	logic       fin, sep_chk, nm_use;
	logic [1:0] cnt_add;
	logic [6:0] cnt_base;
	logic [7:0] cnt_sum;
	logic [2:0] fbit;
	reject_t    why;

	assign c   = item.char_byte;
	assign tok = is_token(c);
	assign sp  = is_space(c);

	dahp_name_match u_name (
		.restart    (phase_q != PH_NAME),
		.cands      (cands_q),
		.pos        (npos_q),
		.c          (c),
		.cands_next (nm_cands),
		.pos_next   (nm_pos),
		.field      (nm_field)
	);

	always_comb begin
		phase_n    = phase_q;
		spos_n     = spos_q;
		smatch_n   = smatch_q;
		cands_n    = cands_q;
		npos_n     = npos_q;
		field_n    = field_q;
		comma_n    = comma_q;
		esc_n      = esc_q;
		nonempty_n = nonempty_q;
		count_n    = count_q;
		fields_n   = fields_q;
		nonce_ok_n = nonce_ok_q;
		res        = '0;
		fin        = 1'b0;
		sep_chk    = 1'b0;
		nm_use     = 1'b0;
		cnt_add    = 2'd0;
		cnt_base   = count_q;
		cnt_sum    = 8'd0;
		fbit       = 3'd0;
		why        = REJ_NONE;

		case (phase_q)
			PH_START: begin
				if (sp) begin
					phase_n = PH_START;
				end else if (tok) begin
					smatch_n = (c == SCHEME_WORD[0]);
					spos_n   = 3'd1;
					phase_n  = PH_SCHEME;
				end else begin
					phase_n = PH_ERR_SYNTAX;
				end
			end
			PH_SCHEME: begin
				if (tok) begin
					if (!(spos_q < SCHEME_LEN && c == SCHEME_WORD[spos_q]))
						smatch_n = 1'b0;
					if (spos_q != 3'd7)
						spos_n = spos_q + 3'd1;
				end else if (c == CH_SP) begin
					phase_n = (smatch_q && spos_q == SCHEME_LEN) ? PH_SCHEME_END
						: PH_ERR_SCHEME;
				end else begin
					phase_n = PH_ERR_SYNTAX;
				end
			end
			PH_SCHEME_END: begin
				if (c == CH_SP) begin
					phase_n = PH_SCHEME_END;
				end else if (tok) begin
					nm_use  = 1'b1;
					phase_n = PH_NAME;
				end else begin
					phase_n = PH_ERR_SYNTAX;
				end
			end
			PH_NAME: begin
				if (tok) begin
					nm_use = 1'b1;
				end else if (c == CH_EQ) begin
					field_n = nm_field;
					phase_n = PH_VALUE_START;
				end else begin
					phase_n = PH_ERR_SYNTAX;
				end
			end
			PH_VALUE_START: begin
				if (tok) begin
					nonempty_n = 1'b0;
					esc_n      = 1'b0;
					cnt_base   = 7'd0;
					cnt_add    = 2'd1;
					res.value_valid = 1'b1;
					res.value_byte  = c;
					phase_n    = PH_TOKEN;
					fin        = item.last_byte;
				end else if (c == CH_DQUOTE) begin
					nonempty_n = 1'b0;
					count_n    = 7'd0;
					esc_n      = 1'b0;
					phase_n    = PH_QUOTED;
				end else begin
					phase_n = PH_ERR_SYNTAX;
				end
			end
			PH_TOKEN: begin
				if (tok) begin
					cnt_add = 2'd1;
					res.value_valid = 1'b1;
					res.value_byte  = c;
					fin     = item.last_byte;
				end else begin
					// The ending byte is read again as a separator
					fin     = 1'b1;
					sep_chk = 1'b1;
				end
			end
			PH_QUOTED: begin
				if (esc_q) begin
					esc_n = 1'b0;
					res.value_valid    = 1'b1;
					res.value_byte     = c;
					res.lead_backslash = c[7];
					cnt_add = c[7] ? 2'd2 : 2'd1;
				end else if (c < CH_SP || c == CH_DEL) begin
					phase_n = PH_ERR_SYNTAX;
				end else if (c == CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (c == CH_DQUOTE) begin
					fin = 1'b1;
				end else begin
					res.value_valid = 1'b1;
					res.value_byte  = c;
					cnt_add = 2'd1;
				end
			end
			PH_LWS: begin
				if (comma_q && tok) begin
					nm_use  = 1'b1;
					phase_n = PH_NAME;
				end else if (c == CH_COMMA) begin
					comma_n = 1'b1;
				end else if (!sp) begin
					phase_n = PH_ERR_SYNTAX;
				end
			end
			PH_ERR_SYNTAX, PH_ERR_SCHEME: begin
				phase_n = phase_q;
			end
			default: begin
				phase_n = PH_ERR_SYNTAX;
			end
		endcase

		if (nm_use) begin
			cands_n = nm_cands;
			npos_n  = nm_pos;
		end

		if (cnt_add != 2'd0) begin
			nonempty_n = 1'b1;
			cnt_sum    = {1'b0, cnt_base} + {6'd0, cnt_add};
			count_n    = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[6:0];
		end

		if (fin) begin
			fbit = 3'(field_q - 4'd1);
			if (field_q inside {[4'd1:4'd8]})
				fields_n[fbit] = nonempty_n;
			if (field_q == FIELD_NONCE)
				nonce_ok_n = (count_n == 7'(NONCE_CHARS));
			phase_n       = PH_LWS;
			comma_n       = 1'b0;
			res.value_end = 1'b1;
		end

		if (sep_chk) begin
			if (c == CH_COMMA)
				comma_n = 1'b1;
			else if (!sp)
				phase_n = PH_ERR_SYNTAX;
		end

		res.field_code = (res.value_valid || res.value_end) ? field_n : FIELD_UNKNOWN;

		if (item.last_byte) begin
			if (phase_n == PH_ERR_SYNTAX)
				why = REJ_SYNTAX;
			else if (phase_n == PH_ERR_SCHEME)
				why = REJ_SCHEME;
			else if (phase_n != PH_LWS)
				why = REJ_TRUNCATED;
			else if (fields_n != FIELDS_ALL)
				why = REJ_MISSING;
			else if (!nonce_ok_n)
				why = REJ_NONCE_LEN;
			res.header_done     = 1'b1;
			res.header_accepted = (why == REJ_NONE);
			res.reject_reason   = why;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			spos_q     <= 3'd0;
			smatch_q   <= 1'b1;
			cands_q    <= '1;
			npos_q     <= 4'd0;
			field_q    <= FIELD_UNKNOWN;
			comma_q    <= 1'b0;
			esc_q      <= 1'b0;
			nonempty_q <= 1'b0;
			count_q    <= 7'd0;
			fields_q   <= 8'd0;
			nonce_ok_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				// drop back to the start for the next header
				phase_q    <= PH_START;
				spos_q     <= 3'd0;
				smatch_q   <= 1'b1;
				cands_q    <= '1;
				npos_q     <= 4'd0;
				field_q    <= FIELD_UNKNOWN;
				comma_q    <= 1'b0;
				esc_q      <= 1'b0;
				nonempty_q <= 1'b0;
				count_q    <= 7'd0;
				fields_q   <= 8'd0;
				nonce_ok_q <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				spos_q     <= spos_n;
				smatch_q   <= smatch_n;
				cands_q    <= cands_n;
				npos_q     <= npos_n;
				field_q    <= field_n;
				comma_q    <= comma_n;
				esc_q      <= esc_n;
				nonempty_q <= nonempty_n;
				count_q    <= count_n;
				fields_q   <= fields_n;
				nonce_ok_q <= nonce_ok_n;
			end
		end
	end

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parse phase not one-hot");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> phase_q == PH_START && fields_q == 8'd0)
		else $error("parser did not restart after last byte");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.header_accepted |-> res.header_done && res.reject_reason == REJ_NONE
			&& fields_n == FIELDS_ALL)
		else $error("header accepted with a reject reason or missing field");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_ERR_SYNTAX || phase_q == PH_ERR_SCHEME)
			|-> !res.value_valid && !res.value_end)
		else $error("value output after an error");

endmodule

// ===== rtl/core/digest_auth_header_parser_top.sv =====
`timescale 1ns / 1ps

// Digest Authorization header parser.
// req channel: one header byte per beat (char_byte, last_byte marks the final
// byte of a header value). rsp channel: exactly one result beat per request
// beat, in order. Each result tags a value byte with its field code, flags the
// end of a value, and on the last byte carries header_done with the verdict
// (header_accepted, reject_reason).
// Path: an accepted byte waits in the input register, is parsed, and its
// result is loaded into the result register, where the receiver takes it
// (input register, then result register).
// Throughput: one byte per cycle while rsp_stall does not hold a full result
// register; the next-state logic is a single pass over one byte.
// Stall: while rsp_stall holds the result register, one more byte is taken
// into the input register; only then is req_stall raised.
// Reset: arst_n clears the valid flags of both registers and puts the parser
// at the start of a header. After the last byte of a header the parser returns
// to that state on its own, so headers may follow back to back.
module digest_auth_header_parser_top import dahp_pkg::*; #(
	parameter int unsigned NONCE_CHARS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	logic item_valid_s1;
	req_t item_s1;
	logic adv;
	rsp_t result;

	// Advance the held byte when the result register is empty or being drained
	assign adv       = item_valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = item_valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (adv) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_data;
		end
	end

	dahp_parse #(
		.NONCE_CHARS (NONCE_CHARS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (result)
	);

	// Result register: hold while stalled, load on every advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_data <= result;
		end
	end

endmodule
